// ===== hdl/uer_pkg.sv =====
// Shared types and constants for the ultrasonic echo ranger.
`timescale 1ns / 1ps

package uer_pkg;

  // Field widths
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 16;
  localparam int unsigned TickW   = 16;
  localparam int unsigned DistW   = 13;
  localparam int unsigned FailW   = 4;

  // Fixed sequencing constants
  localparam logic [TickW-1:0] TrigLowTicks = 16'd2;
  localparam logic [TickW-1:0] TickMax      = 16'hFFFF;
  localparam logic [DistW-1:0] Q4Max        = 13'd8191;
  localparam logic [FailW-1:0] FailSat      = 4'd15;

  // floor(x / 29) as (x * DivRecip) >> DivShift, exact for x below 2^19
  localparam int unsigned      DivInW   = 19;
  localparam int unsigned      DivShift = 24;
  localparam int unsigned      DivRecW  = 20;
  localparam logic [DivRecW-1:0] DivRecip = 20'd578525;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_SETTLE_WAIT   = 3'd0,
    REG_TRIGGER_WIDTH = 3'd1,
    REG_RISE_TIMEOUT  = 3'd2,
    REG_ECHO_MAX      = 3'd3,
    REG_MIN_ECHO      = 3'd4,
    REG_MAX_ECHO      = 3'd5,
    REG_FAIL_LIMIT    = 3'd6
  } cfg_reg_e;

  // Measurement phases, one-hot
  typedef enum logic [5:0] {
    PH_IDLE      = 6'b000001,
    PH_SETTLE    = 6'b000010,
    PH_TRIG_LOW  = 6'b000100,
    PH_TRIG_HIGH = 6'b001000,
    PH_WAIT_RISE = 6'b010000,
    PH_MEASURE   = 6'b100000
  } phase_e;

  typedef struct packed {
    logic [TickW-1:0] settle_wait_us;
    logic [7:0]       trigger_width_us;
    logic [TickW-1:0] rise_timeout_us;
    logic [TickW-1:0] echo_max_us;
    logic [TickW-1:0] min_echo_us;
    logic [TickW-1:0] max_echo_us;
    logic [FailW-1:0] fail_limit;
  } cfg_t;

  // Result of one tick item
  typedef struct packed {
    logic             trig;
    logic             busy_res;
    logic             done_res;
    logic             ok;
    logic [DistW-1:0] reported_q4;
    logic [DistW-1:0] latest_q4;
    logic [FailW-1:0] fail_run;
  } res_t;

endpackage

// ===== hdl/uer_in_if.sv =====
// Tick item channel: measurement request and sampled echo level.
`timescale 1ns / 1ps

interface uer_in_if;
  logic valid;
  logic ready;
  logic cmd;
  logic echo;

  modport source (output valid, output cmd, output echo, input ready);
  modport sink (input valid, input cmd, input echo, output ready);
endinterface

// ===== hdl/uer_out_if.sv =====
// Result item channel: trigger level, status and distances.
`timescale 1ns / 1ps

interface uer_out_if;
  import uer_pkg::*;

  logic             valid;
  logic             ready;
  logic             trig;
  logic             busy_res;
  logic             done_res;
  logic             ok;
  logic [DistW-1:0] reported_q4;
  logic [DistW-1:0] latest_q4;
  logic [FailW-1:0] fail_run;

  modport source (output valid, output trig, output busy_res, output done_res, output ok,
                  output reported_q4, output latest_q4, output fail_run, input ready);
  modport sink (input valid, input trig, input busy_res, input done_res, input ok,
                input reported_q4, input latest_q4, input fail_run, output ready);
endinterface

// ===== hdl/uer_cfg_if.sv =====
// Configuration write channel: register index and write data.
`timescale 1ns / 1ps

interface uer_cfg_if;
  import uer_pkg::*;

  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [CfgDatW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/ultrasonic_echo_ranger.sv =====
// Top level of the ultrasonic echo ranger.
`timescale 1ns / 1ps

// Time-of-flight ranging sequencer for an ultrasonic echo sensor.
// in_i carries one item per microsecond tick: cmd (1 = also request a
// measurement) and the sampled echo level. out_o returns exactly one item
// per tick item: the trigger level for the next tick, busy, done, ok, the
// reported and latest distances in 1/16 cm, and the failure run.
// cfg_i writes the seven configuration registers by index; it is always
// ready and is meant to be used only while the block is idle.
// An item accepted into the input register is processed and captured in
// the result register, and out_o.valid rises when it is captured.
// Throughput: one item per cycle while results are taken; the sequencer
// takes one step per item and the distance is a single reciprocal
// multiply in that same step.
// Reset clears the input and output stages, puts the sequencer in idle with
// zero counters and distances, and restores the default register values.
// When the receiver stalls, the result register holds, the input register
// fills, and in_i.ready drops until the result is taken.
module ultrasonic_echo_ranger (
  input  logic     clk_i,
  input  logic     rst_ni,
  uer_in_if.sink   in_i,
  uer_out_if.source out_o,
  uer_cfg_if.sink  cfg_i
);
  import uer_pkg::*;

  cfg_t cfg;
  res_t res;
  res_t res_q;
  logic in_vld_q, out_vld_q, advance;
  logic cmd_q, echo_q;

  uer_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // Handshake: step when an item waits and the result register is free
  assign advance    = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      cmd_q  <= in_i.cmd;
      echo_q <= in_i.echo;
    end
  end

  uer_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .cmd_i  (cmd_q),
    .echo_i (echo_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (!out_vld_q || out_o.ready) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.trig        = res_q.trig;
  assign out_o.busy_res    = res_q.busy_res;
  assign out_o.done_res    = res_q.done_res;
  assign out_o.ok          = res_q.ok;
  assign out_o.reported_q4 = res_q.reported_q4;
  assign out_o.latest_q4   = res_q.latest_q4;
  assign out_o.fail_run    = res_q.fail_run;

  // A finished measurement always returns to idle
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && res_q.done_res) |-> !res_q.busy_res)
    else $error("done result still busy");

  // A valid result clears the failure run
  a_ok_clears_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && res_q.ok) |-> (res_q.done_res && res_q.fail_run == '0))
    else $error("ok without done or with failure run");

  // Trigger is driven only inside a measurement
  a_trig_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && res_q.trig) |-> res_q.busy_res)
    else $error("trigger outside measurement");

  // The report is either zeroed or the last valid distance
  a_report_latest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && res_q.reported_q4 != '0) |-> (res_q.reported_q4 == res_q.latest_q4))
    else $error("reported distance differs from latest");

endmodule

// ===== hdl/uer_cfg_regs.sv =====
// Configuration register file with reset defaults.
`timescale 1ns / 1ps

module uer_cfg_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  uer_cfg_if.sink       cfg_i,
  output uer_pkg::cfg_t cfg_o
);
  import uer_pkg::*;

  cfg_t cfg_q;
  logic wr_en;

  assign cfg_i.ready = 1'b1;
  assign wr_en       = cfg_i.valid;
  assign cfg_o       = cfg_q;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.settle_wait_us   <= 16'd3000;
      cfg_q.trigger_width_us <= 8'd10;
      cfg_q.rise_timeout_us  <= 16'd6000;
      cfg_q.echo_max_us      <= 16'd25000;
      cfg_q.min_echo_us      <= 16'd116;
      cfg_q.max_echo_us      <= 16'd23200;
      cfg_q.fail_limit       <= 4'd4;
    end else if (wr_en) begin
      case (cfg_i.index)
        REG_SETTLE_WAIT:   cfg_q.settle_wait_us   <= cfg_i.data;
        REG_TRIGGER_WIDTH: cfg_q.trigger_width_us <= cfg_i.data[7:0];
        REG_RISE_TIMEOUT:  cfg_q.rise_timeout_us  <= cfg_i.data;
        REG_ECHO_MAX:      cfg_q.echo_max_us      <= cfg_i.data;
        REG_MIN_ECHO:      cfg_q.min_echo_us      <= cfg_i.data;
        REG_MAX_ECHO:      cfg_q.max_echo_us      <= cfg_i.data;
        REG_FAIL_LIMIT:    cfg_q.fail_limit       <= cfg_i.data[FailW-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/uer_dist_calc.sv =====
// Echo length to distance in 1/16 cm: floor(len * 16 / 58), saturated.
`timescale 1ns / 1ps

module uer_dist_calc (
  input  logic [uer_pkg::TickW-1:0] len_i,
  output logic [uer_pkg::DistW-1:0] dist_o
);
  import uer_pkg::*;

  localparam int unsigned ProdW = DivInW + DivRecW;
  localparam int unsigned QuotW = ProdW - DivShift;

  logic [ProdW-1:0] prod;
  logic [QuotW-1:0] quot;

  // len * 8 / 29 through a reciprocal multiply
  assign prod   = ProdW'({len_i, 3'b000}) * ProdW'(DivRecip);
  assign quot   = prod[ProdW-1:DivShift];
  assign dist_o = (quot > QuotW'(Q4Max)) ? Q4Max : quot[DistW-1:0];

endmodule

// ===== hdl/uer_seq.sv =====
// Measurement sequencer: phase, tick counter, failure run and distances.
`timescale 1ns / 1ps

module uer_seq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  logic          cmd_i,
  input  logic          echo_i,
  input  uer_pkg::cfg_t cfg_i,
  output uer_pkg::res_t res_o
);
  import uer_pkg::*;

  phase_e           phase_q, phase_d, ph_cur;
  logic [TickW-1:0] tick_q, tick_d, tc_cur, tc_inc, emax;
  logic [FailW-1:0] fail_q, fail_d, fail_inc;
  logic [DistW-1:0] held_q, held_d, last_q, last_d, dist_q4;
  logic             start, fail, done, ok, in_window;

  // A request from idle opens the settle step on this same tick
  assign start     = (phase_q == PH_IDLE) && cmd_i;
  assign ph_cur    = start ? PH_SETTLE : phase_q;
  assign tc_cur    = start ? '0 : tick_q;
  assign tc_inc    = (tc_cur == TickMax) ? TickMax : tc_cur + 16'd1;
  assign fail_inc  = (fail_q == FailSat) ? FailSat : fail_q + 4'd1;
  assign emax      = (cfg_i.echo_max_us == '0) ? 16'd1 : cfg_i.echo_max_us;
  assign in_window = (tc_cur >= cfg_i.min_echo_us) && (tc_cur <= cfg_i.max_echo_us);

  uer_dist_calc u_dist (
    .len_i  (tc_cur),
    .dist_o (dist_q4)
  );

  // Next state for one tick
  always_comb begin
    phase_d = ph_cur;
    tick_d  = tc_cur;
    fail_d  = fail_q;
    held_d  = held_q;
    last_d  = last_q;
    fail    = 1'b0;
    done    = 1'b0;
    ok      = 1'b0;
    case (ph_cur)
      PH_IDLE: ;
      PH_SETTLE: begin
        if (!echo_i) begin
          phase_d = PH_TRIG_LOW;
          tick_d  = '0;
        end else begin
          tick_d = tc_inc;
          if (tc_inc >= cfg_i.settle_wait_us) begin
            fail    = 1'b1;
            done    = 1'b1;
            phase_d = PH_IDLE;
          end
        end
      end
      PH_TRIG_LOW: begin
        tick_d = tc_inc;
        if (tc_inc >= TrigLowTicks) begin
          phase_d = PH_TRIG_HIGH;
          tick_d  = '0;
        end
      end
      PH_TRIG_HIGH: begin
        tick_d = tc_inc;
        if (tc_inc >= {8'b0, cfg_i.trigger_width_us}) begin
          phase_d = PH_WAIT_RISE;
          tick_d  = '0;
        end
      end
      PH_WAIT_RISE: begin
        if (echo_i) begin
          phase_d = PH_MEASURE;
          tick_d  = 16'd1;
        end else begin
          tick_d = tc_inc;
          if (tc_inc >= cfg_i.rise_timeout_us) begin
            fail    = 1'b1;
            done    = 1'b1;
            phase_d = PH_IDLE;
          end
        end
      end
      PH_MEASURE: begin
        if (echo_i) begin
          if (tc_cur >= emax) begin
            fail    = 1'b1;
            done    = 1'b1;
            phase_d = PH_IDLE;
          end else begin
            tick_d = tc_inc;
          end
        end else begin
          done    = 1'b1;
          phase_d = PH_IDLE;
          if (in_window) begin
            ok     = 1'b1;
            fail_d = '0;
            held_d = dist_q4;
            last_d = dist_q4;
          end else begin
            fail = 1'b1;
          end
        end
      end
      default: phase_d = PH_IDLE;
    endcase
    // Failure run: saturating count, zero the report past the limit
    if (fail) begin
      fail_d = fail_inc;
      if (fail_inc > cfg_i.fail_limit) begin
        held_d = '0;
      end
    end
  end

  // Result of this tick
  assign res_o.trig        = (phase_d == PH_TRIG_HIGH);
  assign res_o.busy_res    = (phase_d != PH_IDLE);
  assign res_o.done_res    = done;
  assign res_o.ok          = ok;
  assign res_o.reported_q4 = held_d;
  assign res_o.latest_q4   = last_d;
  assign res_o.fail_run    = fail_d;

  // State advances once per processed item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      tick_q  <= '0;
      fail_q  <= '0;
      held_q  <= '0;
      last_q  <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      fail_q  <= fail_d;
      held_q  <= held_d;
      last_q  <= last_d;
    end
  end

endmodule

// ===== tb/tb.sv =====
// Testbench for the ultrasonic echo ranger: scripted echo sequences checked tick by tick.
`timescale 1ns / 1ps

module tb;
  import uer_pkg::*;

  localparam int unsigned CycleLimit  = 5_000_000;
  localparam int unsigned RandomTicks = 300;
  localparam int unsigned RandomDone  = 8;
  localparam int unsigned MaxReports  = 40;
  localparam int unsigned Q4Scale     = 16;
  localparam int unsigned CmDivisor   = 58;
  // Index with no register behind it; writes there must change nothing
  localparam logic [CfgIdxW-1:0] CfgIdxUnused = 3'd7;

  logic clk;
  logic rst_n;

  uer_in_if  in_if ();
  uer_out_if out_if ();
  uer_cfg_if cfg_if ();

  ultrasonic_echo_ranger u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // Predicted sequencer state and register copy
  cfg_t             cfg_shadow;
  phase_e           ph;
  logic [TickW-1:0] tick_cnt;
  logic [FailW-1:0] fail_cnt;
  logic [DistW-1:0] held_q4;
  logic [DistW-1:0] last_q4;

  res_t        tick_results_q[$];
  int unsigned ticks_sent = 0;
  int unsigned n_done     = 0;
  int unsigned n_ok       = 0;
  int unsigned n_settings = 0;
  int unsigned n_errors   = 0;
  int unsigned cycles     = 0;
  int unsigned stall_left = 0;
  bit          gaps_on    = 1'b1;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Gap length: mostly none, sometimes a few cycles, rarely a long one
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [TickW-1:0] sat_inc(logic [TickW-1:0] v);
    return (v == TickMax) ? v : v + 16'd1;
  endfunction

  function automatic void note_failure();
    if (fail_cnt != FailSat) fail_cnt = fail_cnt + 4'd1;
    if (fail_cnt > cfg_shadow.fail_limit) held_q4 = '0;
  endfunction

  // One sequencer step per tick item; returns the result that tick produces
  function automatic res_t ranging_step(bit req, bit echo);
    res_t             r;
    bit               done;
    bit               ok;
    logic [TickW-1:0] emax;
    int unsigned      dist_q4;
    done = 1'b0;
    ok   = 1'b0;
    emax = (cfg_shadow.echo_max_us == '0) ? 16'd1 : cfg_shadow.echo_max_us;
    if (ph == PH_IDLE && req) begin
      ph       = PH_SETTLE;
      tick_cnt = '0;
    end
    case (ph)
      PH_SETTLE: begin
        if (!echo) begin
          ph       = PH_TRIG_LOW;
          tick_cnt = '0;
        end else begin
          tick_cnt = sat_inc(tick_cnt);
          if (tick_cnt >= cfg_shadow.settle_wait_us) begin
            note_failure();
            done = 1'b1;
            ph   = PH_IDLE;
          end
        end
      end
      PH_TRIG_LOW: begin
        tick_cnt = sat_inc(tick_cnt);
        if (tick_cnt >= TrigLowTicks) begin
          ph       = PH_TRIG_HIGH;
          tick_cnt = '0;
        end
      end
      PH_TRIG_HIGH: begin
        tick_cnt = sat_inc(tick_cnt);
        if (tick_cnt >= {8'd0, cfg_shadow.trigger_width_us}) begin
          ph       = PH_WAIT_RISE;
          tick_cnt = '0;
        end
      end
      PH_WAIT_RISE: begin
        if (echo) begin
          // rising tick is the first echo tick
          ph       = PH_MEASURE;
          tick_cnt = 16'd1;
        end else begin
          tick_cnt = sat_inc(tick_cnt);
          if (tick_cnt >= cfg_shadow.rise_timeout_us) begin
            note_failure();
            done = 1'b1;
            ph   = PH_IDLE;
          end
        end
      end
      PH_MEASURE: begin
        if (echo) begin
          if (tick_cnt >= emax) begin
            note_failure();
            done = 1'b1;
            ph   = PH_IDLE;
          end else begin
            tick_cnt = sat_inc(tick_cnt);
          end
        end else begin
          if (tick_cnt >= cfg_shadow.min_echo_us && tick_cnt <= cfg_shadow.max_echo_us) begin
            dist_q4 = (int'(tick_cnt) * Q4Scale) / CmDivisor;
            if (dist_q4 > Q4Max) dist_q4 = Q4Max;
            fail_cnt = '0;
            held_q4  = DistW'(dist_q4);
            last_q4  = DistW'(dist_q4);
            ok       = 1'b1;
          end else begin
            note_failure();
          end
          done = 1'b1;
          ph   = PH_IDLE;
        end
      end
      default: ph = PH_IDLE;
    endcase
    if (done) n_done++;
    if (ok) n_ok++;
    r.trig        = (ph == PH_TRIG_HIGH);
    r.busy_res    = (ph != PH_IDLE);
    r.done_res    = done;
    r.ok          = done && ok;
    r.reported_q4 = held_q4;
    r.latest_q4   = last_q4;
    r.fail_run    = fail_cnt;
    return r;
  endfunction

  // Send one tick item; predict its result once it is accepted
  task automatic send_tick(bit req, bit echo);
    int unsigned gap;
    gap = gaps_on ? idle_len() : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.cmd   <= req;
    in_if.echo  <= echo;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    tick_results_q.push_back(ranging_step(req, echo));
    ticks_sent++;
  endtask

  // One measurement: settle_hi leftover echo ticks, rise_dly quiet ticks
  // after the trigger, then an echo of echo_len ticks
  task automatic measure(int unsigned settle_hi, int unsigned rise_dly,
                         int unsigned echo_len, bit noisy);
    bit          req;
    bit          echo;
    bit          first;
    int unsigned sh;
    int unsigned rd;
    int unsigned len_left;
    sh       = settle_hi;
    rd       = rise_dly;
    len_left = 0;
    first    = 1'b1;
    do begin
      case (ph)
        PH_IDLE, PH_SETTLE: begin
          echo = (sh != 0);
          if (sh != 0) sh--;
        end
        PH_WAIT_RISE: begin
          if (rd == 0) begin
            echo     = 1'b1;
            len_left = (echo_len > 1) ? echo_len - 1 : 0;
          end else begin
            echo = 1'b0;
            rd--;
          end
        end
        PH_MEASURE: begin
          echo = (len_left != 0);
          if (len_left != 0) len_left--;
        end
        // echo is ignored while the trigger runs
        default: echo = 1'($urandom_range(0, 1));
      endcase
      req = first || (noisy && $urandom_range(0, 5) == 0);
      send_tick(req, echo);
      first = 1'b0;
    end while (ph != PH_IDLE);
  endtask

  // Bring the sequencer to idle and wait for every result
  task automatic drain();
    while (ph != PH_IDLE) send_tick(1'b0, ph == PH_WAIT_RISE);
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (tick_results_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDatW-1:0] val);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    case (idx)
      REG_SETTLE_WAIT:   cfg_shadow.settle_wait_us   = val;
      REG_TRIGGER_WIDTH: cfg_shadow.trigger_width_us = val[7:0];
      REG_RISE_TIMEOUT:  cfg_shadow.rise_timeout_us  = val;
      REG_ECHO_MAX:      cfg_shadow.echo_max_us      = val;
      REG_MIN_ECHO:      cfg_shadow.min_echo_us      = val;
      REG_MAX_ECHO:      cfg_shadow.max_echo_us      = val;
      REG_FAIL_LIMIT:    cfg_shadow.fail_limit       = val[FailW-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // Write all registers while idle; width_junk fills the unused upper bits
  task automatic apply_config(cfg_t c, logic [7:0] width_junk);
    drain();
    write_reg(REG_SETTLE_WAIT, c.settle_wait_us);
    write_reg(REG_TRIGGER_WIDTH, {width_junk, c.trigger_width_us});
    write_reg(REG_RISE_TIMEOUT, c.rise_timeout_us);
    write_reg(REG_ECHO_MAX, c.echo_max_us);
    write_reg(REG_MIN_ECHO, c.min_echo_us);
    write_reg(REG_MAX_ECHO, c.max_echo_us);
    write_reg(REG_FAIL_LIMIT, CfgDatW'(c.fail_limit));
    n_settings++;
  endtask

  // Register values after reset: lower window edge, request while busy
  task automatic test_default_ranging();
    n_settings++;
    measure(5, 20, 150, 1'b0);
    measure(0, 0, 116, 1'b0);
    measure(2, 10, 115, 1'b0);
    measure(0, 7, 160, 1'b1);
  endtask

  // Short limits, zero and one limits, zeroing with a fail limit of zero
  task automatic test_timeouts_and_zero_limits();
    cfg_t c;
    c = '{settle_wait_us: 16'd3, trigger_width_us: 8'd0, rise_timeout_us: 16'd4,
          echo_max_us: 16'd0, min_echo_us: 16'd0, max_echo_us: 16'hFFFF, fail_limit: 4'd0};
    apply_config(c, 8'h00);
    measure(1, 0, 1, 1'b0);
    measure(3, 0, 1, 1'b0);
    measure(0, 4, 1, 1'b0);
    measure(0, 0, 2, 1'b0);
    measure(0, 1, 1, 1'b0);
    c.settle_wait_us   = 16'd0;
    c.rise_timeout_us  = 16'd1;
    c.trigger_width_us = 8'd1;
    c.echo_max_us      = 16'd3;
    apply_config(c, 8'hA5);
    measure(1, 0, 1, 1'b0);
    measure(0, 1, 2, 1'b0);
    measure(0, 0, 3, 1'b0);
    measure(0, 0, 4, 1'b0);
  endtask

  // Failure run saturates at 15 and never zeroes the report at limit 15
  task automatic test_fail_run_saturation();
    cfg_t c;
    c = '{settle_wait_us: 16'd0, trigger_width_us: 8'd2, rise_timeout_us: 16'd5,
          echo_max_us: 16'd50, min_echo_us: 16'd10, max_echo_us: 16'd40, fail_limit: 4'd15};
    apply_config(c, 8'h00);
    measure(0, 2, 20, 1'b0);
    repeat (17) measure(1, 0, 1, 1'b0);
    c.fail_limit = 4'd14;
    apply_config(c, 8'h00);
    measure(1, 0, 1, 1'b0);
  endtask

  // Largest and smallest register values, unused index, empty valid window
  task automatic test_register_extremes();
    cfg_t c;
    gaps_on = 1'b0;
    c = '{settle_wait_us: 16'hFFFF, trigger_width_us: 8'hFF, rise_timeout_us: 16'hFFFF,
          echo_max_us: 16'hFFFF, min_echo_us: 16'd0, max_echo_us: 16'hFFFF, fail_limit: 4'd15};
    apply_config(c, 8'hFF);
    write_reg(CfgIdxUnused, 16'hFFFF);
    measure(3, 10, 40, 1'b0);
    c = '{settle_wait_us: 16'd2, trigger_width_us: 8'd1, rise_timeout_us: 16'd2,
          echo_max_us: 16'd1, min_echo_us: 16'hFFFF, max_echo_us: 16'd0, fail_limit: 4'd0};
    apply_config(c, 8'h00);
    measure(0, 0, 1, 1'b0);
    measure(1, 1, 1, 1'b0);
    measure(0, 0, 2, 1'b0);
    drain();
    gaps_on = 1'b1;
  endtask

  // Random settings; mostly complete measurements, some broken ones and noise
  task automatic test_random_mix();
    cfg_t        c;
    logic [7:0]  junk;
    int unsigned start_ticks;
    int unsigned start_done;
    int unsigned emax;
    int unsigned sl;
    int unsigned rl;
    int unsigned kind;
    int          len;
    start_ticks = ticks_sent;
    start_done  = n_done;
    while (ticks_sent - start_ticks < RandomTicks || n_done - start_done < RandomDone) begin
      c.settle_wait_us   = 16'($urandom_range(0, 15));
      c.trigger_width_us = 8'($urandom_range(0, 5));
      c.rise_timeout_us  = 16'($urandom_range(0, 25));
      c.echo_max_us      = 16'($urandom_range(0, 60));
      c.min_echo_us      = 16'($urandom_range(0, 40));
      c.max_echo_us      = 16'($urandom_range(c.min_echo_us, 80));
      c.fail_limit       = 4'($urandom_range(0, 15));
      if ($urandom_range(0, 9) == 0) c.min_echo_us = 16'($urandom_range(0, 65535)) | 16'h8000;
      if ($urandom_range(0, 9) == 0) c.max_echo_us = 16'($urandom_range(0, 65535));
      junk    = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'h00;
      gaps_on = ($urandom_range(0, 3) != 0);
      apply_config(c, junk);
      emax = (c.echo_max_us == 0) ? 1 : c.echo_max_us;
      sl   = (c.settle_wait_us > 1) ? c.settle_wait_us - 1 : 0;
      rl   = (c.rise_timeout_us > 1) ? c.rise_timeout_us - 1 : 0;
      repeat (8) begin
        kind = $urandom_range(0, 9);
        if (kind < 7) begin
          len = $urandom_range(1, emax);
          // aim at the edges of the valid window now and then
          if ($urandom_range(0, 2) == 0) begin
            len = ($urandom_range(0, 1) != 0) ? int'(c.min_echo_us) : int'(c.max_echo_us);
            len = len + int'($urandom_range(0, 2)) - 1;
            if (len < 1) len = 1;
            if (len > int'(emax) + 1) len = emax + 1;
          end
          measure($urandom_range(0, sl), $urandom_range(0, rl), len,
                  $urandom_range(0, 4) == 0);
        end else if (kind == 7) begin
          case ($urandom_range(0, 2))
            0:       measure(sl + 1 + $urandom_range(0, 3), 0, 1, 1'b0);
            1:       measure(0, rl + 1 + $urandom_range(0, 3), 1, 1'b0);
            default: measure(0, 0, emax + 1 + $urandom_range(0, 3), 1'b0);
          endcase
        end else begin
          repeat ($urandom_range(3, 20))
            send_tick($urandom_range(0, 7) == 0, 1'($urandom_range(0, 1)));
          while (ph != PH_IDLE) send_tick(1'b0, 1'($urandom_range(0, 1)));
        end
      end
    end
    gaps_on = 1'b1;
  endtask

  // Result side stalls
  always @(negedge clk) begin : out_stall
    int unsigned n;
    if (!gaps_on) begin
      stall_left = 0;
      out_if.ready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      out_if.ready <= 1'b0;
    end else begin
      n = idle_len();
      stall_left = (n != 0) ? n - 1 : 0;
      out_if.ready <= (n == 0);
    end
  end

  function automatic void check_field(string name, logic [DistW-1:0] want,
                                      logic [DistW-1:0] got);
    if (got !== want) begin
      n_errors++;
      if (n_errors <= MaxReports)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin : check_results
    res_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (tick_results_q.size() == 0) begin
        n_errors++;
        if (n_errors <= MaxReports)
          $display("%0t: result with no tick pending, expected none, got busy=%0b done=%0b",
                   $time, out_if.busy_res, out_if.done_res);
      end else begin
        want = tick_results_q.pop_front();
        check_field("trig", DistW'(want.trig), DistW'(out_if.trig));
        check_field("busy_res", DistW'(want.busy_res), DistW'(out_if.busy_res));
        check_field("done_res", DistW'(want.done_res), DistW'(out_if.done_res));
        check_field("ok", DistW'(want.ok), DistW'(out_if.ok));
        check_field("reported_q4", want.reported_q4, out_if.reported_q4);
        check_field("latest_q4", want.latest_q4, out_if.latest_q4);
        check_field("fail_run", DistW'(want.fail_run), DistW'(out_if.fail_run));
      end
    end
  end

  // Run-length guard
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : main
    rst_n        = 1'b0;
    in_if.valid  = 1'b0;
    in_if.cmd    = 1'b0;
    in_if.echo   = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data  = '0;
    out_if.ready = 1'b0;
    cfg_shadow = '{settle_wait_us: 16'd3000, trigger_width_us: 8'd10,
                   rise_timeout_us: 16'd6000, echo_max_us: 16'd25000,
                   min_echo_us: 16'd116, max_echo_us: 16'd23200, fail_limit: 4'd4};
    ph       = PH_IDLE;
    tick_cnt = '0;
    fail_cnt = '0;
    held_q4  = '0;
    last_q4  = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_default_ranging();
    test_timeouts_and_zero_limits();
    test_fail_run_saturation();
    test_register_extremes();
    test_random_mix();
    drain();

    $display("Ran %0d tick items under %0d register settings.", ticks_sent, n_settings);
    $display("%0d measurements finished, %0d of them valid; %0d mismatches.",
             n_done, n_ok, n_errors);
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/uer_pkg.sv
hdl/uer_in_if.sv
hdl/uer_out_if.sv
hdl/uer_cfg_if.sv
hdl/uer_cfg_regs.sv
hdl/uer_dist_calc.sv
hdl/uer_seq.sv
hdl/ultrasonic_echo_ranger.sv
tb/tb.sv
